/* rtl/bdm_pkg.sv */
package bdm_pkg;

    localparam int BDM_MAX_WIDTH  = 1024;
    localparam int BDM_MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 10;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd320;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd200;
    localparam logic [CFG_W-1:0] FRAME_MIN        = 11'd3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    // Q16 luma weights, sum is 65536
    localparam int LUMA_W = 16;
    localparam logic [LUMA_W-1:0] LUMA_R = 16'd13933;
    localparam logic [LUMA_W-1:0] LUMA_G = 16'd46871;
    localparam logic [LUMA_W-1:0] LUMA_B = 16'd4732;

    // 3x3 neighborhood: rows u/m/d, columns l/k/n
    typedef struct packed {
        logic [PIX_W-1:0] ul;
        logic [PIX_W-1:0] uk;
        logic [PIX_W-1:0] un;
        logic [PIX_W-1:0] ml;
        logic [PIX_W-1:0] mk;
        logic [PIX_W-1:0] mn;
        logic [PIX_W-1:0] dl;
        logic [PIX_W-1:0] dk;
        logic [PIX_W-1:0] dn;
    } t_win;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] luma;
    } t_color;

endpackage

/* rtl/bdm_in_if.sv */
interface bdm_in_if
    import bdm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] raw_pixel;
    logic             is_padding;

    modport source (output valid, output raw_pixel, output is_padding, input ready);
    modport sink   (input valid, input raw_pixel, input is_padding, output ready);
endinterface

/* rtl/bdm_out_if.sv */
interface bdm_out_if
    import bdm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic [PIX_W-1:0]   luma;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic               frame_last;

    modport source (output valid, output red, output green, output blue, output luma,
                    output pixel_col, output pixel_row, output frame_last, input ready);
    modport sink   (input valid, input red, input green, input blue, input luma,
                    input pixel_col, input pixel_row, input frame_last, output ready);
endinterface

/* rtl/bdm_line_store.sv */
module bdm_line_store
    import bdm_pkg::*;
#(
    parameter int DEPTH = BDM_MAX_WIDTH,
    parameter int AW    = $clog2(BDM_MAX_WIDTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [PIX_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the reading stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bdm_interp.sv */
module bdm_interp
    import bdm_pkg::*;
(
    input  t_win   i_win,
    input  logic   i_x_odd,
    input  logic   i_y_odd,
    input  logic   i_border,
    output t_color o_color
);

    logic [PIX_W+1:0] diag_sum;
    logic [PIX_W+1:0] cross_sum;
    logic [PIX_W:0]   horz_sum;
    logic [PIX_W:0]   vert_sum;
    logic [PIX_W-1:0] diag;
    logic [PIX_W-1:0] cross_avg;
    logic [PIX_W-1:0] horz;
    logic [PIX_W-1:0] vert;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [23:0]      luma_acc;

    assign diag_sum  = (PIX_W+2)'(i_win.ul) + (PIX_W+2)'(i_win.un)
                     + (PIX_W+2)'(i_win.dl) + (PIX_W+2)'(i_win.dn);
    assign cross_sum = (PIX_W+2)'(i_win.uk) + (PIX_W+2)'(i_win.dk)
                     + (PIX_W+2)'(i_win.ml) + (PIX_W+2)'(i_win.mn);
    assign horz_sum  = (PIX_W+1)'(i_win.ml) + (PIX_W+1)'(i_win.mn);
    assign vert_sum  = (PIX_W+1)'(i_win.uk) + (PIX_W+1)'(i_win.dk);

    // interpolated channels are forced to zero on the frame border
    assign diag      = i_border ? '0 : diag_sum[PIX_W+1:2];
    assign cross_avg = i_border ? '0 : cross_sum[PIX_W+1:2];
    assign horz      = i_border ? '0 : horz_sum[PIX_W:1];
    assign vert      = i_border ? '0 : vert_sum[PIX_W:1];

    always_comb begin
        case ({i_y_odd, i_x_odd})
            2'b00: begin   // blue site
                red = diag;  green = cross_avg; blue = i_win.mk;
            end
            2'b01: begin   // green on blue row
                red = vert;  green = i_win.mk; blue = horz;
            end
            2'b10: begin   // green on red row
                red = horz;  green = i_win.mk; blue = vert;
            end
            default: begin // red site
                red = i_win.mk; green = cross_avg; blue = diag;
            end
        endcase
    end

    assign luma_acc = 24'(LUMA_R) * 24'(red)
                    + 24'(LUMA_G) * 24'(green)
                    + 24'(LUMA_B) * 24'(blue);

    assign o_color.red   = red;
    assign o_color.green = green;
    assign o_color.blue  = blue;
    assign o_color.luma  = luma_acc[23:16];

endmodule

/* rtl/bayer_bilinear_demosaic_luma.sv */
// An accepted input is registered in stage 1, then its result in the output register.
// Throughput: one input transaction per cycle; each grid item reads its column of both
// line stores and writes back the previous column in the same cycle, so only a waiting
// result holds the input.
// Reset (synchronous, active low) clears the grid counters, the window registers, the
// pipeline valid flags and sets the frame size to 320x200; line stores are not cleared.
module bayer_bilinear_demosaic_luma
    import bdm_pkg::*;
#(
    parameter int MAX_WIDTH = BDM_MAX_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    bdm_in_if.sink               i_pix,
    bdm_out_if.source            o_pix
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = (CW > CFG_W) ? CW : CFG_W;
    localparam int RW = CFG_W;

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [WW-1:0]    fw_ext;
    logic [CW-1:0]    eff_w;
    logic [RW-1:0]    eff_h;

    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [CW-1:0]    n_col;
    logic [RW-1:0]    n_row;

    logic             r_s1_v;
    logic [PIX_W-1:0] r_s1_pix;
    logic [CW-1:0]    r_s1_col;
    logic [RW-1:0]    r_s1_row;

    logic [PIX_W-1:0] r_win [6];

    logic             r_out_v;
    t_color           r_out_color;
    logic [COORD_W-1:0] r_out_col;
    logic [COORD_W-1:0] r_out_row;
    logic             r_out_last;

    logic             in_fire;
    logic             out_can;
    logic             s1_adv;
    logic             s1_inr;
    logic             s1_emit;
    logic [CW-1:0]    s1_x;
    logic [RW-1:0]    s1_y;
    logic             s1_border;
    logic             s1_last;
    logic [PIX_W-1:0] prev_q;
    logic [PIX_W-1:0] prev2_q;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    t_win             win;
    t_color           color;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp the frame size to the supported range
    assign fw_ext = WW'(r_frame_width);

    always_comb begin
        if (fw_ext < WW'(FRAME_MIN)) begin
            eff_w = CW'(FRAME_MIN);
        end else if (fw_ext > WW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(fw_ext);
        end
        if (r_frame_height < FRAME_MIN) begin
            eff_h = FRAME_MIN;
        end else if (r_frame_height > RW'(BDM_MAX_HEIGHT)) begin
            eff_h = RW'(BDM_MAX_HEIGHT);
        end else begin
            eff_h = r_frame_height;
        end
    end

    // handshake
    assign out_can     = !r_out_v || o_pix.ready;
    assign s1_adv      = r_s1_v && out_can;
    assign i_pix.ready = !r_s1_v || s1_adv;
    assign in_fire     = i_pix.valid && i_pix.ready;

    // grid position of the incoming item
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_fire) begin
            if (r_col >= eff_w) begin
                n_col = '0;
                n_row = (r_row >= eff_h) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_s1_v <= in_fire || (r_s1_v && !s1_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pix <= i_pix.is_padding ? '0 : i_pix.raw_pixel;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
        end
    end

    // line stores: read on accept, write back when an in-range item leaves stage 1
    bdm_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_prev (
        .i_clk   (i_clk),
        .i_we    (s1_adv && s1_inr),
        .i_waddr (r_s1_col[AW-1:0]),
        .i_wdata (r_s1_pix),
        .i_re    (in_fire),
        .i_raddr (r_col[AW-1:0]),
        .o_rdata (prev_q)
    );

    bdm_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_prev2 (
        .i_clk   (i_clk),
        .i_we    (s1_adv && s1_inr),
        .i_waddr (r_s1_col[AW-1:0]),
        .i_wdata (mid),
        .i_re    (in_fire),
        .i_raddr (r_col[AW-1:0]),
        .o_rdata (prev2_q)
    );

    assign s1_inr = r_s1_col < eff_w;
    assign top    = s1_inr ? prev2_q : '0;
    assign mid    = s1_inr ? prev_q  : '0;

    assign win.ul = r_win[0];
    assign win.ml = r_win[1];
    assign win.dl = r_win[2];
    assign win.uk = r_win[3];
    assign win.mk = r_win[4];
    assign win.dk = r_win[5];
    assign win.un = top;
    assign win.mn = mid;
    assign win.dn = r_s1_pix;

    assign s1_emit   = (r_s1_col != '0) && (r_s1_row != '0);
    assign s1_x      = r_s1_col - 1'b1;
    assign s1_y      = r_s1_row - 1'b1;
    assign s1_border = (s1_x == '0) || (s1_y == '0)
                    || (s1_x == eff_w - 1'b1) || (s1_y == eff_h - 1'b1);
    assign s1_last   = (s1_x == eff_w - 1'b1) && (s1_y == eff_h - 1'b1);

    bdm_interp u_interp (
        .i_win    (win),
        .i_x_odd  (s1_x[0]),
        .i_y_odd  (s1_y[0]),
        .i_border (s1_border),
        .o_color  (color)
    );

    // shift the window one column left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= r_s1_pix;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= (r_out_v && !o_pix.ready) || (s1_adv && s1_emit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_emit) begin
            r_out_color <= color;
            r_out_col   <= COORD_W'(s1_x);
            r_out_row   <= COORD_W'(s1_y);
            r_out_last  <= s1_last;
        end
    end

    assign o_pix.valid      = r_out_v;
    assign o_pix.red        = r_out_color.red;
    assign o_pix.green      = r_out_color.green;
    assign o_pix.blue       = r_out_color.blue;
    assign o_pix.luma       = r_out_color.luma;
    assign o_pix.pixel_col  = r_out_col;
    assign o_pix.pixel_row  = r_out_row;
    assign o_pix.frame_last = r_out_last;

endmodule
